### rtl/core/tdm_pkg.sv
// Shared types and constants of the touch-drag to mouse report converter.
// Used by every module of the block; depends on nothing.
package tdm_pkg;

	localparam int DeltaLimit = 127;
	localparam int MaxChunks  = 64;

	localparam logic [31:0] TapTimeUs = 32'd220000;
	localparam logic [35:0] TapDistSq = 36'd36864;
	localparam logic [9:0]  AccelCap  = 10'd640;
	// Smallest length at which floor(len * 24 / 25) reaches the cap.
	localparam logic [17:0] AccelKnee = 18'd667;

	localparam logic [10:0] SpeedReset = 11'd461;

	typedef enum logic [1:0] {
		REQ_BEGIN  = 2'd0,
		REQ_UPDATE = 2'd1,
		REQ_END    = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		KIND_MOVE  = 2'd0,
		KIND_DOWN  = 2'd1,
		KIND_UP    = 2'd2,
		KIND_CLICK = 2'd3
	} kind_t;

	typedef enum logic {
		CFG_POINTER_SPEED = 1'b0,
		CFG_HOLD_ON_DRAG  = 1'b1
	} cfg_t;

	typedef struct packed {
		req_t               req;
		logic signed [16:0] ox;
		logic signed [16:0] oy;
		logic [31:0]        t;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

### rtl/core/tdm_front.sv
// Front end: accepts drag events, drops unknown requests and queues the rest.
// Uses tdm_pkg for the queue entry type.
module tdm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            req_type,
	input  logic signed [16:0]    offset_x,
	input  logic signed [16:0]    offset_y,
	input  logic [31:0]           time_us,
	output tdm_pkg::queue_head_t  head,
	input  logic                  pop
);

	tdm_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           do_pop;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall && (tdm_pkg::req_t'(req_type) != tdm_pkg::REQ_NONE);
	assign do_pop   = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q].req <= tdm_pkg::req_t'(req_type);
			entry_q[wr_ptr_q].ox  <= offset_x;
			entry_q[wr_ptr_q].oy  <= offset_y;
			entry_q[wr_ptr_q].t   <= time_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !do_pop) count_q <= count_q + 2'd1;
			else if (!push && do_pop) count_q <= count_q - 2'd1;
		end
	end

endmodule

### rtl/core/tdm_back.sv
// Back end: sequencer that runs one queued event at a time and drives the
// report register. Uses tdm_pkg; fed by tdm_front.
module tdm_back #(
	parameter int DELTA_LIMIT = tdm_pkg::DeltaLimit,
	parameter int MAX_CHUNKS  = tdm_pkg::MaxChunks
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tdm_pkg::queue_head_t head,
	output logic                 pop,
	input  logic [10:0]          speed,
	input  logic                 hold,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           report_kind,
	output logic signed [7:0]    move_x,
	output logic signed [7:0]    move_y,
	output logic                 last
);

	localparam int CW = $clog2(MAX_CHUNKS + 1);
	localparam logic signed [20:0] LIM = 21'(DELTA_LIMIT);

	typedef enum logic [17:0] {
		ST_IDLE = 18'h00001,
		ST_DIFF = 18'h00002,
		ST_SQX  = 18'h00004,
		ST_SQY  = 18'h00008,
		ST_SUM  = 18'h00010,
		ST_ROOT = 18'h00020,
		ST_GAIN = 18'h00040,
		ST_DIV  = 18'h00080,
		ST_CORR = 18'h00100,
		ST_FACT = 18'h00200,
		ST_MX   = 18'h00400,
		ST_MY   = 18'h00800,
		ST_SCY  = 18'h01000,
		ST_EMIT = 18'h02000,
		ST_TX   = 18'h04000,
		ST_TY   = 18'h08000,
		ST_TSUM = 18'h10000,
		ST_ONE  = 18'h20000
	} state_t;

	function automatic logic [16:0] mag17(input logic signed [17:0] v);
		logic signed [17:0] n;
		n = -v;
		return v[17] ? n[16:0] : v[16:0];
	endfunction

	state_t              state_q;
	logic signed [16:0]  ox_q, oy_q;
	logic [31:0]         t_q;
	logic signed [16:0]  prev_x_q, prev_y_q;
	logic signed [8:0]   rem_x_q, rem_y_q;
	logic [31:0]         start_q;
	logic                held_q;
	logic signed [17:0]  dx_q, dy_q;
	logic [37:0]         prod_q;
	logic [35:0]         sum_q, rad_q;
	logic [19:0]         srem_q;
	logic [17:0]         root_q;
	logic [4:0]          iter_q;
	logic [14:0]         gx_q;
	logic                cap_q;
	logic [9:0]          gain_q;
	logic [20:0]         factor_q;
	logic signed [20:0]  mx_q, my_q;
	logic [CW-1:0]       n_q;
	tdm_pkg::kind_t      kind_q;
	logic                out_valid_q;

	logic [16:0] absx, absy, absox, absoy;
	logic [16:0] mul_a;
	logic [20:0] mul_b;

	assign absx  = mag17(dx_q);
	assign absy  = mag17(dy_q);
	assign absox = mag17({ox_q[16], ox_q});
	assign absoy = mag17({oy_q[16], oy_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQX: begin mul_a = absx; mul_b = 21'(absx); end
			ST_SQY: begin mul_a = absy; mul_b = 21'(absy); end
			ST_DIV: begin mul_a = 17'(gx_q); mul_b = 21'd1310; end
			ST_FACT: begin mul_a = 17'(speed); mul_b = 21'(gain_q) + 21'd256; end
			ST_MX: begin mul_a = absx; mul_b = prod_q[20:0]; end
			ST_MY: begin mul_a = absy; mul_b = factor_q; end
			ST_TX: begin mul_a = absox; mul_b = 21'(absox); end
			ST_TY: begin mul_a = absoy; mul_b = 21'(absoy); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Square root: one result bit per cycle, restoring.
	logic [21:0] rem2, trial;
	assign rem2  = {srem_q, rad_q[35:34]};
	assign trial = 22'({root_q, 2'b01});

	// Gain divide by 25: the reciprocal underestimates by less than one step.
	logic [10:0] q0;
	logic [15:0] r25;
	assign q0  = prod_q[25:15];
	assign r25 = 16'(gx_q) - 16'(q0) * 16'd25;

	// Axis scaling shared by both axes, from the product register.
	logic               sc_neg;
	logic signed [8:0]  sc_rem;
	logic [25:0]        q8;
	logic signed [27:0] q8s, acc, nacc;
	logic [27:0]        absacc;
	logic signed [20:0] whole;
	logic signed [8:0]  rem_new;

	always_comb begin
		sc_neg  = (state_q == ST_MY) ? dx_q[17] : dy_q[17];
		sc_rem  = (state_q == ST_MY) ? rem_x_q : rem_y_q;
		q8      = prod_q[37:12];
		q8s     = sc_neg ? -$signed({2'b00, q8}) : $signed({2'b00, q8});
		acc     = q8s + 28'(sc_rem);
		nacc    = -acc;
		absacc  = acc[27] ? nacc : acc;
		whole   = acc[27] ? -$signed({1'b0, absacc[27:8]}) : $signed({1'b0, absacc[27:8]});
		rem_new = acc[27] ? -$signed({1'b0, absacc[7:0]}) : $signed({1'b0, absacc[7:0]});
	end

	// Chunk clamp.
	logic signed [7:0]  sx, sy;
	logic signed [20:0] nx, ny;
	logic               motion, last_chunk, out_free, wr;

	always_comb begin
		if (mx_q > LIM) sx = LIM[7:0];
		else if (mx_q < -LIM) sx = 8'(-LIM);
		else sx = mx_q[7:0];
		if (my_q > LIM) sy = LIM[7:0];
		else if (my_q < -LIM) sy = 8'(-LIM);
		else sy = my_q[7:0];
		nx         = mx_q - 21'(sx);
		ny         = my_q - 21'(sy);
		motion     = (mx_q != '0) || (my_q != '0);
		last_chunk = ((nx == '0) && (ny == '0)) || (n_q == CW'(MAX_CHUNKS - 1));
	end

	assign out_free = !out_valid_q || !out_stall;
	assign wr       = out_free && (((state_q == ST_EMIT) && motion) || (state_q == ST_ONE));
	assign pop      = (state_q == ST_IDLE) && head.valid;

	always_ff @(posedge clk) begin
		prod_q <= 38'(mul_a) * 38'(mul_b);
		if (pop) begin
			ox_q <= head.item.ox;
			oy_q <= head.item.oy;
			t_q  <= head.item.t;
		end
		if (state_q == ST_DIFF) begin
			dx_q <= {ox_q[16], ox_q} - {prev_x_q[16], prev_x_q};
			dy_q <= {oy_q[16], oy_q} - {prev_y_q[16], prev_y_q};
		end
		if (state_q == ST_SQY || state_q == ST_TY) sum_q <= prod_q[35:0];
		if (state_q == ST_GAIN) begin
			cap_q <= (root_q >= tdm_pkg::AccelKnee);
			gx_q  <= 15'(root_q[9:0]) * 15'd24;
		end
		if (state_q == ST_CORR) begin
			if (cap_q) gain_q <= tdm_pkg::AccelCap;
			else if (r25 >= 16'd25) gain_q <= 10'(q0 + 11'd1);
			else gain_q <= q0[9:0];
		end
		if (state_q == ST_MX) factor_q <= prod_q[20:0];
		if (wr) begin
			if (state_q == ST_EMIT) begin
				report_kind <= tdm_pkg::KIND_MOVE;
				move_x      <= sx;
				move_y      <= sy;
				last        <= last_chunk;
			end else begin
				report_kind <= kind_q;
				move_x      <= '0;
				move_y      <= '0;
				last        <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			rem_x_q     <= '0;
			rem_y_q     <= '0;
			start_q     <= '0;
			held_q      <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= tdm_pkg::KIND_MOVE;
			rad_q       <= '0;
			srem_q      <= '0;
			root_q      <= '0;
			iter_q      <= '0;
			mx_q        <= '0;
			my_q        <= '0;
			n_q         <= '0;
		end else begin
			if (wr) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head.item.req)
							tdm_pkg::REQ_BEGIN: begin
								prev_x_q <= '0;
								prev_y_q <= '0;
								rem_x_q  <= '0;
								rem_y_q  <= '0;
								start_q  <= head.item.t;
								if (hold) begin
									held_q  <= 1'b1;
									kind_q  <= tdm_pkg::KIND_DOWN;
									state_q <= ST_ONE;
								end
							end
							tdm_pkg::REQ_UPDATE: state_q <= ST_DIFF;
							tdm_pkg::REQ_END: begin
								if (held_q) begin
									held_q  <= 1'b0;
									kind_q  <= tdm_pkg::KIND_UP;
									state_q <= ST_ONE;
								end else begin
									state_q <= ST_TX;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DIFF: begin
					prev_x_q <= ox_q;
					prev_y_q <= oy_q;
					state_q  <= ST_SQX;
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: state_q <= ST_SUM;
				ST_SUM: begin
					rad_q   <= sum_q + prod_q[35:0];
					srem_q  <= '0;
					root_q  <= '0;
					iter_q  <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (rem2 >= trial) begin
						srem_q <= 20'(rem2 - trial);
						root_q <= {root_q[16:0], 1'b1};
					end else begin
						srem_q <= rem2[19:0];
						root_q <= {root_q[16:0], 1'b0};
					end
					rad_q  <= {rad_q[33:0], 2'b00};
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'd17) state_q <= ST_GAIN;
				end
				ST_GAIN: state_q <= ST_DIV;
				ST_DIV:  state_q <= ST_CORR;
				ST_CORR: state_q <= ST_FACT;
				ST_FACT: state_q <= ST_MX;
				ST_MX:   state_q <= ST_MY;
				ST_MY: begin
					mx_q    <= whole;
					rem_x_q <= rem_new;
					state_q <= ST_SCY;
				end
				ST_SCY: begin
					my_q    <= whole;
					rem_y_q <= rem_new;
					n_q     <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!motion) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						mx_q <= nx;
						my_q <= ny;
						n_q  <= n_q + CW'(1);
						if (last_chunk) state_q <= ST_IDLE;
					end
				end
				ST_TX: state_q <= ST_TY;
				ST_TY: state_q <= ST_TSUM;
				ST_TSUM: begin
					if ((t_q - start_q) < tdm_pkg::TapTimeUs &&
					    (sum_q + prod_q[35:0]) < tdm_pkg::TapDistSq) begin
						kind_q  <= tdm_pkg::KIND_CLICK;
						state_q <= ST_ONE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_ONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/touch_drag_to_mouse_reports_unit.sv
// Top level of the touch-drag to mouse report converter: configuration
// registers, front end queue and back end sequencer. Uses tdm_pkg.
//
//   channel | direction | handshake          | payload
//   in      | in        | in_valid/in_stall  | req_type offset_x offset_y time_us
//   out     | out       | out_valid/out_stall| report_kind move_x move_y last
//   cfg     | in        | cfg_we             | cfg_index cfg_data
//
// In the back end an update runs the difference, the squares, a square root that
// resolves one bit per cycle, the gain and the axis scaling before its first move
// report, then emits its move reports, waiting while the output is stalled.
// The front queue holds two events, so input is taken while the back end works.
// Reset clears all drag state and sets the registers to their reset values.
// A stalled output holds its report; the back end waits with it.
module touch_drag_to_mouse_reports_unit #(
	parameter int DELTA_LIMIT = tdm_pkg::DeltaLimit,
	parameter int MAX_CHUNKS  = tdm_pkg::MaxChunks
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [16:0] offset_x,
	input  logic signed [16:0] offset_y,
	input  logic [31:0]        time_us,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         report_kind,
	output logic signed [7:0]  move_x,
	output logic signed [7:0]  move_y,
	output logic               last,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [10:0]        cfg_data
);

	logic [10:0]          speed_q;
	logic                 hold_q;
	tdm_pkg::queue_head_t head;
	logic                 pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= tdm_pkg::SpeedReset;
			hold_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (tdm_pkg::cfg_t'(cfg_index))
				tdm_pkg::CFG_POINTER_SPEED: speed_q <= cfg_data;
				tdm_pkg::CFG_HOLD_ON_DRAG:  hold_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tdm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.offset_x (offset_x),
		.offset_y (offset_y),
		.time_us  (time_us),
		.head     (head),
		.pop      (pop)
	);

	tdm_back #(
		.DELTA_LIMIT (DELTA_LIMIT),
		.MAX_CHUNKS  (MAX_CHUNKS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.speed       (speed_q),
		.hold        (hold_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.report_kind (report_kind),
		.move_x      (move_x),
		.move_y      (move_y),
		.last        (last)
	);

endmodule

### rtl/core/tdm_checker.sv
// Port-level checks on the converter's report channel, bound to the top level.
// Uses tdm_pkg for report kinds.
module tdm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         report_kind,
	input logic signed [7:0]  move_x,
	input logic signed [7:0]  move_y,
	input logic               last
);

	// A stalled report stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("report dropped while stalled");

	// A stalled report keeps its contents.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(report_kind) && $stable(move_x) &&
		$stable(move_y) && $stable(last))
		else $error("stalled report changed");

	// Button transactions carry no motion and always end their event.
	a_button_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_kind != tdm_pkg::KIND_MOVE |->
		move_x == 8'sd0 && move_y == 8'sd0 && last)
		else $error("button report with motion or not last");

	// A move transaction has motion and never reaches the most negative code.
	a_move_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_kind == tdm_pkg::KIND_MOVE |->
		(move_x != 8'sd0 || move_y != 8'sd0) && move_x != -8'sd128 && move_y != -8'sd128)
		else $error("move report out of range");

endmodule

bind touch_drag_to_mouse_reports_unit tdm_checker u_tdm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.report_kind (report_kind),
	.move_x      (move_x),
	.move_y      (move_y),
	.last        (last)
);
